// File: rtl/rgsn_pkg.sv
// ----------------------------------------------------------------------------
// rgsn_pkg
// Shared types and constants of the pixel gain / overflow normalize pipeline.
// ----------------------------------------------------------------------------
package rgsn_pkg;

    localparam int FRAC_W = 12;
    localparam int CH_N   = 3;
    localparam int PIX_W  = 8;
    localparam int PROD_W = 24;
    localparam int REM_W  = 16;
    localparam int CFG_W  = 16;
    localparam int QBITS  = 8;

    localparam logic [PROD_W-1:0] OVER_LIM = PROD_W'(255) << FRAC_W;
    localparam logic [2:0]        CH_MIN   = 3'd3;
    localparam logic [2:0]        CH_RST   = 3'd4;
    localparam logic [CFG_W-1:0]  GAIN_RST = 16'h1000;

    localparam logic REG_GAIN = 1'b0;
    localparam logic REG_CHAN = 1'b1;

    typedef logic [CH_N-1:0][PIX_W-1:0]  rgsn_pix_t;
    typedef logic [CH_N-1:0][PROD_W-1:0] rgsn_prod_t;
    typedef logic [CH_N-1:0][REM_W-1:0]  rgsn_rem_t;

    // after max stage
    typedef struct packed {
        rgsn_pix_t        c;
        logic [PIX_W-1:0] mx;
        logic [PIX_W-1:0] a;
        logic             last;
        logic             pass;
    } rgsn_max_t;

    // after multiply stage
    typedef struct packed {
        rgsn_pix_t         c;
        rgsn_prod_t        pc;
        rgsn_rem_t         c255;
        logic [PROD_W-1:0] pm;
        logic [PIX_W-1:0]  mx;
        logic [PIX_W-1:0]  a;
        logic              last;
        logic              pass;
    } rgsn_mul_t;

    // through the divider steps
    typedef struct packed {
        rgsn_pix_t        res;
        rgsn_rem_t        rem;
        rgsn_pix_t        q;
        logic [PIX_W-1:0] mx;
        logic [PIX_W-1:0] a;
        logic             last;
        logic             sel_div;
    } rgsn_div_t;

endpackage

// File: rtl/rgsn_max_stage.sv
// ----------------------------------------------------------------------------
// rgsn_max_stage
// Registers the pixel with its largest color channel and the bypass flag.
// ----------------------------------------------------------------------------
module rgsn_max_stage (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  logic                     in_valid,
    input  rgsn_pkg::rgsn_pix_t      c_in,
    input  logic [rgsn_pkg::PIX_W-1:0] a_in,
    input  logic                     last_in,
    input  logic [2:0]               chan_cnt,
    output logic                     out_valid,
    output rgsn_pkg::rgsn_max_t      out_data
);
    import rgsn_pkg::*;

    logic       valid_reg;
    rgsn_max_t  data_reg;
    rgsn_max_t  data_next;
    logic [PIX_W-1:0] m01;

    always_comb
    begin
        m01            = (c_in[1] > c_in[0]) ? c_in[1] : c_in[0];
        data_next.c    = c_in;
        data_next.mx   = (c_in[2] > m01) ? c_in[2] : m01;
        data_next.a    = a_in;
        data_next.last = last_in;
        data_next.pass = (chan_cnt < CH_MIN);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// File: rtl/rgsn_mul_stage.sv
// ----------------------------------------------------------------------------
// rgsn_mul_stage
// Gain products of the three channels and of the maximum, plus c*255.
// ----------------------------------------------------------------------------
module rgsn_mul_stage (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_valid,
    input  rgsn_pkg::rgsn_max_t        in_data,
    input  logic [rgsn_pkg::CFG_W-1:0] gain,
    output logic                       out_valid,
    output rgsn_pkg::rgsn_mul_t        out_data
);
    import rgsn_pkg::*;

    logic       valid_reg;
    rgsn_mul_t  data_reg;
    rgsn_mul_t  data_next;

    always_comb
    begin
        data_next.c    = in_data.c;
        data_next.mx   = in_data.mx;
        data_next.a    = in_data.a;
        data_next.last = in_data.last;
        data_next.pass = in_data.pass;
        data_next.pm   = PROD_W'(in_data.mx) * PROD_W'(gain);
        for (int i = 0; i < CH_N; i++)
        begin
            data_next.pc[i]   = PROD_W'(in_data.c[i]) * PROD_W'(gain);
            data_next.c255[i] = {in_data.c[i], 8'h00} - REM_W'(in_data.c[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// File: rtl/rgsn_sel_stage.sv
// ----------------------------------------------------------------------------
// rgsn_sel_stage
// Overflow decision, scaled result for the in-range case, divider setup.
// ----------------------------------------------------------------------------
module rgsn_sel_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  rgsn_pkg::rgsn_mul_t in_data,
    output logic                out_valid,
    output rgsn_pkg::rgsn_div_t out_data
);
    import rgsn_pkg::*;

    logic       valid_reg;
    rgsn_div_t  data_reg;
    rgsn_div_t  data_next;

    always_comb
    begin
        data_next.mx      = in_data.mx;
        data_next.a       = in_data.a;
        data_next.last    = in_data.last;
        data_next.sel_div = !in_data.pass && (in_data.pm > OVER_LIM);
        data_next.q       = '0;
        data_next.rem     = in_data.c255;
        for (int i = 0; i < CH_N; i++)
        begin
            data_next.res[i] = in_data.pass ? in_data.c[i]
                                            : in_data.pc[i][FRAC_W +: PIX_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && data_reg.sel_div |-> data_reg.mx != '0)
        else $error("overflow path with zero maximum");

    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !data_reg.sel_div && data_reg.mx == '0 |-> data_reg.res == '0)
        else $error("black pixel not black");

    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && data_reg.sel_div |-> data_reg.rem[0] <= {data_reg.mx, 8'h00})
        else $error("dividend out of quotient range");

endmodule

// File: rtl/rgsn_div_step.sv
// ----------------------------------------------------------------------------
// rgsn_div_step
// One restoring-division step: resolves quotient bit SHIFT on all channels.
// ----------------------------------------------------------------------------
module rgsn_div_step #(
    parameter int SHIFT = 7
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  rgsn_pkg::rgsn_div_t in_data,
    output logic                out_valid,
    output rgsn_pkg::rgsn_div_t out_data
);
    import rgsn_pkg::*;

    logic             valid_reg;
    rgsn_div_t        data_reg;
    rgsn_div_t        data_next;
    logic [REM_W-1:0] dsh;

    always_comb
    begin
        dsh       = REM_W'(in_data.mx) << SHIFT;
        data_next = in_data;
        for (int i = 0; i < CH_N; i++)
        begin
            if (in_data.rem[i] >= dsh)
            begin
                data_next.rem[i]      = in_data.rem[i] - dsh;
                data_next.q[i][SHIFT] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// File: rtl/rgb_gamma_scale_normalize_core.sv
// ----------------------------------------------------------------------------
// rgb_gamma_scale_normalize_core
// Pixel gain with overflow normalize, 12-stage pipeline.
//
//   channel   signals                                   handshake
//   pixel in  red_in green_in blue_in alpha_in last_in  in_valid / in_ready
//   pixel out red_out green_out blue_out alpha_out ...  out_valid / out_ready
//   config    cfg_wr_en cfg_addr cfg_wdata              write enable, no wait
//
// One pixel per cycle unless out_ready stalls; stages: max, multiply,
// select, eight restoring-division steps for c*255/max, output register.
// Stall ripples back through a per-stage ready chain; a bubble stage always
// accepts, so nothing is lost or repeated.
// Reset clears stage valids and loads gain 1.0 and channel count 4.
// ----------------------------------------------------------------------------
module rgb_gamma_scale_normalize_core (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic                       cfg_addr,
    input  logic [rgsn_pkg::CFG_W-1:0] cfg_wdata,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [7:0]                 red_in,
    input  logic [7:0]                 green_in,
    input  logic [7:0]                 blue_in,
    input  logic [7:0]                 alpha_in,
    input  logic                       last_in,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [7:0]                 red_out,
    output logic [7:0]                 green_out,
    output logic [7:0]                 blue_out,
    output logic [7:0]                 alpha_out,
    output logic                       last_out
);
    import rgsn_pkg::*;

    logic [CFG_W-1:0] gain_reg;
    logic [2:0]       chan_reg;

    logic        v1, v2;
    rgsn_max_t   d1;
    rgsn_mul_t   d2;
    logic        en1, en2;

    logic        dv [QBITS+1];
    rgsn_div_t   dd [QBITS+1];
    logic        den [QBITS+2];

    logic        out_valid_reg;
    rgsn_pix_t   col_reg;
    rgsn_pix_t   col_next;
    logic [7:0]  alpha_reg;
    logic        last_reg;
    rgsn_pix_t   c_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= GAIN_RST;
            chan_reg <= CH_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                REG_GAIN: gain_reg <= cfg_wdata;
                REG_CHAN: chan_reg <= cfg_wdata[2:0];
                default:  gain_reg <= gain_reg;
            endcase
        end
    end

    assign c_in = {blue_in, green_in, red_in};

    assign den[QBITS+1] = !out_valid_reg || out_ready;
    assign en2          = !v2 || den[0];
    assign en1          = !v1 || en2;
    assign in_ready     = en1;

    rgsn_max_stage u_max (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en1),
        .in_valid  (in_valid),
        .c_in      (c_in),
        .a_in      (alpha_in),
        .last_in   (last_in),
        .chan_cnt  (chan_reg),
        .out_valid (v1),
        .out_data  (d1)
    );

    rgsn_mul_stage u_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en2),
        .in_valid  (v1),
        .in_data   (d1),
        .gain      (gain_reg),
        .out_valid (v2),
        .out_data  (d2)
    );

    rgsn_sel_stage u_sel (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (den[0]),
        .in_valid  (v2),
        .in_data   (d2),
        .out_valid (dv[0]),
        .out_data  (dd[0])
    );

    for (genvar j = 0; j <= QBITS; j++)
    begin : g_en
        assign den[j] = !dv[j] || den[j+1];
    end

    for (genvar j = 1; j <= QBITS; j++)
    begin : g_div
        rgsn_div_step #(.SHIFT(QBITS - j)) u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (den[j]),
            .in_valid  (dv[j-1]),
            .in_data   (dd[j-1]),
            .out_valid (dv[j]),
            .out_data  (dd[j])
        );
    end

    assign col_next = dd[QBITS].sel_div ? dd[QBITS].q : dd[QBITS].res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (den[QBITS+1])
        begin
            out_valid_reg <= dv[QBITS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (den[QBITS+1])
        begin
            col_reg   <= col_next;
            alpha_reg <= dd[QBITS].a;
            last_reg  <= dd[QBITS].last;
        end
    end

    assign out_valid = out_valid_reg;
    assign red_out   = col_reg[0];
    assign green_out = col_reg[1];
    assign blue_out  = col_reg[2];
    assign alpha_out = alpha_reg;
    assign last_out  = last_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ready)
        else $error("empty pipeline refuses input");

    assert property (@(posedge clk) disable iff (!rst_n)
        dv[QBITS] && dd[QBITS].sel_div |->
            dd[QBITS].rem[0] < REM_W'(dd[QBITS].mx) &&
            dd[QBITS].rem[1] < REM_W'(dd[QBITS].mx) &&
            dd[QBITS].rem[2] < REM_W'(dd[QBITS].mx))
        else $error("division remainder not below divisor");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> $stable(col_reg) && $stable(last_reg))
        else $error("stalled result changed");

endmodule
